[sv/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the plotter command filter: token phase
// codes, character codes and the command entry passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

	// most bytes one input byte can cause: "!PG" plus ';' LF
	localparam int unsigned PCF_MAX_BYTES   = 5;
	localparam int unsigned PCF_CNT_W       = $clog2(PCF_MAX_BYTES + 1);
	localparam int unsigned PCF_IDX_W       = $clog2(PCF_MAX_BYTES);
	localparam int unsigned PCF_QUEUE_DEPTH = 4;

	// token phase
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_HELD1 = 3'd1,
		PH_BANG  = 3'd2,
		PH_BANGP = 3'd3,
		PH_PASS  = 3'd4,
		PH_DROP  = 3'd5
	} phase_t;

	// character codes
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_U    = 8'h55;

	// one queued command: the bytes caused by one input byte
	typedef struct packed {
		logic [PCF_CNT_W-1:0]              cnt;
		logic [PCF_MAX_BYTES-1:0][7:0]     data;
	} cmd_t;

endpackage

`default_nettype wire

[sv/pcf_front.sv]
// ----------------------------------------------------------------------------
// pcf_front
// Accepts input bytes, tracks the token phase and builds the list of
// output bytes each input byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wire               full,
	input  wire  [7:0]        in_byte,
	input  wire               end_of_data,
	output logic              cmd_valid,
	output pcf_pkg::cmd_t     cmd
);
	import pcf_pkg::*;

	phase_t              phase_q;
	logic [7:0]          held_q;
	logic                stopped_q;

	phase_t              phase_n;
	logic [7:0]          held_n;
	logic                stopped_n;
	logic [PCF_CNT_W-1:0] n;
	logic [PCF_MAX_BYTES-1:0][7:0] d;
	logic                accept;
	logic                is_delim;
	logic                p_second;

	assign accept   = push & ~full;
	assign is_delim = (in_byte == CH_SEMI) || (in_byte == CH_LF) || (in_byte == CH_CR);
	assign p_second = (in_byte == CH_A) || (in_byte == CH_D) || (in_byte == CH_U) ||
		(in_byte == CH_G) || (in_byte == CH_R);

	// classify the byte and build the emitted bytes
	always_comb begin
		n         = '0;
		d         = '0;
		phase_n   = phase_q;
		held_n    = held_q;
		stopped_n = stopped_q;
		if (!stopped_q) begin
			if (in_byte == CH_NUL || is_delim) begin
				if (phase_q == PH_PASS) begin
					d[0] = CH_SEMI;
					d[1] = CH_LF;
					n    = PCF_CNT_W'(2);
				end
				phase_n = PH_START;
				held_n  = '0;
				if (in_byte == CH_NUL) begin
					stopped_n = 1'b1;
				end
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (in_byte == CH_I || in_byte == CH_P) begin
							held_n  = in_byte;
							phase_n = PH_HELD1;
						end else if (in_byte == CH_BANG) begin
							held_n  = in_byte;
							phase_n = PH_BANG;
						end else begin
							phase_n = PH_DROP;
						end
					end
					PH_HELD1: begin
						if ((held_q == CH_I && in_byte == CH_N) ||
							(held_q == CH_P && p_second)) begin
							d[0]    = held_q;
							d[1]    = in_byte;
							n       = PCF_CNT_W'(2);
							phase_n = PH_PASS;
						end else begin
							phase_n = PH_DROP;
						end
						held_n = '0;
					end
					PH_BANG: begin
						if (in_byte == CH_P) begin
							phase_n = PH_BANGP;
						end else begin
							phase_n = PH_DROP;
							held_n  = '0;
						end
					end
					PH_BANGP: begin
						if (in_byte == CH_G) begin
							d[0]    = CH_BANG;
							d[1]    = CH_P;
							d[2]    = CH_G;
							n       = PCF_CNT_W'(3);
							phase_n = PH_PASS;
						end else begin
							phase_n = PH_DROP;
						end
						held_n = '0;
					end
					PH_PASS: begin
						d[0] = in_byte;
						n    = PCF_CNT_W'(1);
					end
					default: begin
						phase_n = PH_DROP;
					end
				endcase
			end
			// end flag closes an open kept token
			if (end_of_data) begin
				if (phase_n == PH_PASS) begin
					d[PCF_IDX_W'(n)]           = CH_SEMI;
					d[PCF_IDX_W'(n + 3'd1)]    = CH_LF;
					n                          = PCF_CNT_W'(n + 3'd2);
				end
				phase_n = PH_START;
				held_n  = '0;
			end
		end
	end

	assign cmd_valid = accept && (n != '0);
	assign cmd.cnt   = n;
	assign cmd.data  = d;

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			held_q    <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			held_q    <= held_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

`default_nettype wire

[sv/pcf_queue.sv]
// ----------------------------------------------------------------------------
// pcf_queue
// Short command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_queue #(
	parameter int unsigned DEPTH = pcf_pkg::PCF_QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_en,
	input  pcf_pkg::cmd_t     wr_cmd,
	output logic              full,
	input  wire               rd_en,
	output logic              rd_valid,
	output pcf_pkg::cmd_t     rd_cmd
);
	import pcf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

[sv/pcf_back.sv]
// ----------------------------------------------------------------------------
// pcf_back
// Walks the bytes of the head command into the result register, one byte per
// cycle while that register is empty or popped, flagging the last byte of each command.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	input  pcf_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              empty,
	input  wire               pop
);
	import pcf_pkg::*;

	logic [PCF_IDX_W-1:0] idx_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic                 valid_q;
	logic                 load;
	logic                 is_last;

	assign load     = ~valid_q | pop;
	assign is_last  = (PCF_CNT_W'(idx_q) == PCF_CNT_W'(cmd.cnt - 1'b1));
	assign cmd_pop  = load & cmd_valid & is_last;
	assign out_byte = byte_q;
	assign run_last = last_q;
	assign empty    = ~valid_q;

	// result register payload
	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			byte_q <= cmd.data[idx_q];
			last_q <= is_last;
		end
	end

	// byte index and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= cmd_valid;
			if (cmd_valid) begin
				idx_q <= is_last ? '0 : PCF_IDX_W'(idx_q + 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

[sv/plotter_command_filter.sv]
// Path: the first result byte of an input passes the command queue, then the result
// register; an input causing n bytes needs n result transfers to drain.
// Throughput: one input byte per cycle while the command queue has room; the back
// end delivers one result byte per cycle while the receiver pops, so inputs causing
// several bytes fill the queue (depth QueueDepth commands) and then stall input.
// Reset: arst_n clears token phase, stop flag, queue and result register.
// ----------------------------------------------------------------------------
// plotter_command_filter
// Filters a plotter command byte stream, keeping only selected commands
// and closing each kept one with ';' and LF.
// ----------------------------------------------------------------------------
`default_nettype none

module plotter_command_filter #(
	parameter int unsigned QueueDepth = pcf_pkg::PCF_QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  in_byte,
	input  wire         end_of_data,
	output logic        empty,
	input  wire         pop,
	output logic [7:0]  out_byte,
	output logic        run_last
);
	import pcf_pkg::*;

	logic  wr_en;
	cmd_t  wr_cmd;
	logic  rd_valid;
	cmd_t  rd_cmd;
	logic  rd_en;

	// classify incoming bytes
	pcf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.end_of_data (end_of_data),
		.cmd_valid   (wr_en),
		.cmd         (wr_cmd)
	);

	// decoupling queue
	pcf_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_cmd   (wr_cmd),
		.full     (full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_cmd   (rd_cmd)
	);

	// serialize commands into result transfers
	pcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (rd_valid),
		.cmd       (rd_cmd),
		.cmd_pop   (rd_en),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

[tb/sv/filter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filter_checker
// Watches both queue sides of the plotter command filter, predicts the
// filtered byte stream from each input transfer and compares every result
// transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------

module filter_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_data,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	output int         fail_count,
	output int         outstanding
);
	import pcf_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} filtered_byte_t;

	// predicted bytes, oldest first
	filtered_byte_t filtered_bytes[$];
	filtered_byte_t want;

	// own copy of the filter state
	phase_t     token_phase;
	logic [7:0] held_byte;
	logic       data_stopped;

	task automatic emit_byte(input logic [7:0] b);
		filtered_bytes.push_back('{value: b, last: 1'b0});
	endtask

	// an open kept command is finished with ';' LF
	task automatic close_kept();
		if (token_phase == PH_PASS) begin
			emit_byte(CH_SEMI);
			emit_byte(CH_LF);
		end
	endtask

	task automatic filter_byte(input logic [7:0] b, input logic fin);
		int first_new;
		first_new = filtered_bytes.size();
		if (!data_stopped) begin
			if (b == CH_NUL) begin
				// zero byte ends the data for good
				close_kept();
				token_phase = PH_START;
				held_byte = '0;
				data_stopped = 1'b1;
			end else if (b == CH_SEMI || b == CH_LF || b == CH_CR) begin
				close_kept();
				token_phase = PH_START;
				held_byte = '0;
			end else begin
				case (token_phase)
					PH_START: begin
						if (b == CH_I || b == CH_P) begin
							held_byte = b;
							token_phase = PH_HELD1;
						end else if (b == CH_BANG) begin
							held_byte = b;
							token_phase = PH_BANG;
						end else begin
							token_phase = PH_DROP;
						end
					end
					PH_HELD1: begin
						if ((held_byte == CH_I && b == CH_N) ||
						    (held_byte == CH_P && (b == CH_A || b == CH_D || b == CH_U ||
						                           b == CH_G || b == CH_R))) begin
							emit_byte(held_byte);
							emit_byte(b);
							token_phase = PH_PASS;
						end else begin
							token_phase = PH_DROP;
						end
						held_byte = '0;
					end
					PH_BANG: begin
						if (b == CH_P) begin
							token_phase = PH_BANGP;
						end else begin
							token_phase = PH_DROP;
							held_byte = '0;
						end
					end
					PH_BANGP: begin
						if (b == CH_G) begin
							emit_byte(CH_BANG);
							emit_byte(CH_P);
							emit_byte(CH_G);
							token_phase = PH_PASS;
						end else begin
							token_phase = PH_DROP;
						end
						held_byte = '0;
					end
					PH_PASS: begin
						emit_byte(b);
					end
					default: begin
						token_phase = PH_DROP;
					end
				endcase
			end
			// end flag closes whatever is open after this byte
			if (fin) begin
				close_kept();
				token_phase = PH_START;
				held_byte = '0;
			end
		end
		if (filtered_bytes.size() > first_new)
			filtered_bytes[filtered_bytes.size() - 1].last = 1'b1;
	endtask

	// compare result transfers, then predict from input transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_phase = PH_START;
			held_byte = '0;
			data_stopped = 1'b0;
			filtered_bytes.delete();
			fail_count = 0;
		end else begin
			if (pop && !empty) begin
				if (filtered_bytes.size() == 0) begin
					$error("unexpected result transfer: out_byte %02h run_last %0b",
					       out_byte, run_last);
					fail_count++;
				end else begin
					want = filtered_bytes.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte mismatch: expected %02h, got %02h",
						       want.value, out_byte);
						fail_count++;
					end
					if (run_last !== want.last) begin
						$error("run_last mismatch: expected %0b, got %0b",
						       want.last, run_last);
						fail_count++;
					end
				end
			end
			if (push && !full)
				filter_byte(in_byte, end_of_data);
		end
		outstanding = filtered_bytes.size();
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the plotter command filter with a short directed byte stream and
// then random commands, broken prefixes and noise under changing idle
// patterns on both sides, including one long receiver hold-off that fills
// the block; the checker beside the block does the prediction.
// ----------------------------------------------------------------------------

module tb_top;
	import pcf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DIRECTED_ITEMS = 23;
	localparam int ITEMS_PER_PASS = 60;
	localparam int LONG_HOLD = 80;
	localparam int DRAIN_CYCLES = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = '0;
	logic       end_of_data = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int items_sent = 0;
	int send_idle_pct = 18;
	int recv_idle_pct = 65;

	plotter_command_filter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.end_of_data (end_of_data),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.run_last    (run_last)
	);

	filter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.end_of_data (end_of_data),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		end_of_data <= fin;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s, input logic fin_last);
		int i;
		for (i = 0; i < s.len(); i++)
			send_item(s[i], fin_last && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] delim_byte();
		case ($urandom_range(0, 2))
			0:       return CH_SEMI;
			1:       return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// mostly printable, sometimes any nonzero byte
	function automatic logic [7:0] payload_byte();
		if ($urandom_range(0, 9) < 8)
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(1, 255));
	endfunction

	// well-formed command with random payload, ended by delimiters or the end flag
	task automatic send_command();
		int n_payload, n_delim, i;
		string pfx;
		case ($urandom_range(0, 6))
			0:       pfx = "IN";
			1:       pfx = "PA";
			2:       pfx = "PD";
			3:       pfx = "PU";
			4:       pfx = "PG";
			5:       pfx = "PR";
			default: pfx = "!PG";
		endcase
		n_payload = $urandom_range(0, 6);
		n_delim = $urandom_range(0, 3);
		send_text(pfx, n_payload == 0 && n_delim == 0);
		for (i = 0; i < n_payload; i++)
			send_item(payload_byte(), n_delim == 0 && i == n_payload - 1);
		for (i = 0; i < n_delim; i++)
			send_item(delim_byte(), i == n_delim - 1 && $urandom_range(0, 7) == 0);
	endtask

	// truncated or wrong prefixes
	task automatic send_broken();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 2))
					0:       send_item(CH_I, 1'b0);
					1:       send_item(CH_P, 1'b0);
					default: send_item(CH_BANG, 1'b0);
				endcase
				send_item(delim_byte(), $urandom_range(0, 3) == 0);
			end
			1: begin
				send_text("!P", $urandom_range(0, 2) == 0);
				send_item(delim_byte(), 1'b0);
			end
			2: begin
				send_item($urandom_range(0, 1) ? CH_I : CH_P, 1'b0);
				send_item(8'($urandom_range(1, 255)), 1'b0);
				send_item(payload_byte(), 1'b0);
				send_item(delim_byte(), 1'b0);
			end
			default: begin
				send_item(CH_BANG, 1'b0);
				send_item(payload_byte(), $urandom_range(0, 3) == 0);
			end
		endcase
	endtask

	// stimulus and verdict
	initial begin
		int pass_no, i, n_noise;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: kept prefixes IN, PA, !PG and PU, short tokens, delimiter runs, end flag
		send_text("IN;", 1'b0);
		send_text("PA", 1'b0);
		send_item(8'hFF, 1'b1);
		send_text("!PG", 1'b1);
		send_item(CH_CR, 1'b0);
		send_item(CH_LF, 1'b0);
		send_text("P;", 1'b0);
		send_text("!P;", 1'b0);
		send_text("XPD;", 1'b0);
		send_text("I", 1'b1);
		send_text("PU", 1'b1);

		// random passes with changing idle patterns
		for (pass_no = 0; pass_no < 3; pass_no++) begin
			case (pass_no)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct <= 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct <= 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			while (items_sent < DIRECTED_ITEMS + ITEMS_PER_PASS * (pass_no + 1)) begin
				i = $urandom_range(0, 99);
				if (i < 70) begin
					send_command();
				end else if (i < 85) begin
					send_broken();
				end else begin
					n_noise = $urandom_range(1, 4);
					for (i = 0; i < n_noise; i++)
						send_item(8'($urandom_range(1, 255)), $urandom_range(0, 9) == 0);
				end
			end
		end

		// zero byte closes the open command, everything after it is ignored
		send_text("PR5", 1'b0);
		send_item(CH_NUL, 1'b0);
		send_text("PA1;", 1'b0);
		send_item(CH_P, 1'b1);
		push <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls, plus one long hold-off once idling stops
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (!hold_done && arst_n && recv_idle_pct == 0) begin
				pop <= 1'b0;
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

endmodule
